// ===== rtl/slc_pkg.sv =====
// shared constants, codes and controller/datapath bundles for the lru write-back cache
// no dependencies
package slc_pkg;

   localparam int MAX_WAYS_DEF   = 8;
   localparam int MAX_SETS_DEF   = 64;
   localparam int BLOCK_BITS_DEF = 30;

   localparam int WAYS_REG_W = 4;
   localparam int SETS_REG_W = 7;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;

   // dividend bits consumed per divider cycle
   localparam int DIV_RADIX = 4;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic ACT_FETCH     = 1'b0;
   localparam logic ACT_WRITEBACK = 1'b1;

   localparam logic REG_WAYS = 1'b0;
   localparam logic REG_SETS = 1'b1;

   typedef struct packed {
      logic accept;
      logic step;
      logic mem_rd;
      logic look;
      logic mem_wr;
      logic show_wb;
   } slc_cmd_type;

   typedef struct packed {
      logic div_last;
      logic hit;
      logic need_wb;
   } slc_stat_type;

endpackage

// ===== rtl/set_assoc_lru_writeback_cache.sv =====
// Set-associative write-back, write-allocate cache tracker with lru replacement. Each request
// is a read or write of a block number; a hit gives no response, a miss gives a fetch
// response (tlast high), preceded by a write-back response when a dirty line is evicted.
// The set is (block / ways) mod sets, found by a shared divider that takes 4 dividend bits
// per cycle, then the set's row is read, looked up and written back, and the responses are
// sent; one request is in flight at a time. Any register write empties the cache at once.
// Top level, depends on slc_pkg, slc_ctrl and slc_dp.
module set_assoc_lru_writeback_cache #(
   parameter int MAX_WAYS   = slc_pkg::MAX_WAYS_DEF,
   parameter int MAX_SETS   = slc_pkg::MAX_SETS_DEF,
   parameter int BLOCK_BITS = slc_pkg::BLOCK_BITS_DEF,
   localparam int DATA_W    = ((BLOCK_BITS + 7) / 8) * 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [DATA_W-1:0]           req_tdata,   // block
   input  logic                        req_tuser,   // operation
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [DATA_W-1:0]           rsp_tdata,   // block_out
   output logic                        rsp_tuser,   // action
   output logic                        rsp_tlast,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [slc_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [slc_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [slc_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);

   slc_pkg::slc_cmd_type  cmd;
   slc_pkg::slc_stat_type stat;
   logic [BLOCK_BITS-1:0] rsp_block;

   assign csr_pready = 1'b1;

   slc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tlast  (rsp_tlast)
   );

   slc_dp #(
      .MAX_WAYS   (MAX_WAYS),
      .MAX_SETS   (MAX_SETS),
      .BLOCK_BITS (BLOCK_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_op     (req_tuser),
      .req_block  (req_tdata[BLOCK_BITS-1:0]),
      .rsp_action (rsp_tuser),
      .rsp_block  (rsp_block),
      .csr_wr     (csr_psel && csr_penable && csr_pwrite),
      .csr_addr   (csr_paddr),
      .csr_wdata  (csr_pwdata),
      .csr_rdata  (csr_prdata)
   );

   assign rsp_tdata = DATA_W'(rsp_block);

endmodule

// ===== rtl/slc_ctrl.sv =====
// sequencing state machine of the lru write-back cache
// depends on slc_pkg
module slc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 rsp_tready,
   input  slc_pkg::slc_stat_type stat,
   output slc_pkg::slc_cmd_type  cmd,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   output logic                 rsp_tlast
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_RD   = 3'd2;
   localparam logic [2:0] ST_LOOK = 3'd3;
   localparam logic [2:0] ST_WR   = 3'd4;
   localparam logic [2:0] ST_OWB  = 3'd5;
   localparam logic [2:0] ST_ORD  = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      rsp_tlast  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
            if (req_tvalid) state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            if (stat.div_last) state_in = ST_RD;
         end
         ST_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_LOOK;
         end
         ST_LOOK: begin
            cmd.look = 1'b1;
            state_in = ST_WR;
         end
         ST_WR: begin
            cmd.mem_wr = 1'b1;
            priority if (stat.hit) state_in = ST_IDLE;
            else if (stat.need_wb) state_in = ST_OWB;
            else state_in = ST_ORD;
         end
         ST_OWB: begin
            rsp_tvalid  = 1'b1;
            cmd.show_wb = 1'b1;
            if (rsp_tready) state_in = ST_ORD;
         end
         ST_ORD: begin
            rsp_tvalid = 1'b1;
            rsp_tlast  = 1'b1;
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

// ===== rtl/slc_dp.sv =====
// datapath: config registers, set-mapping divider, tag/status memories, lru update
// depends on slc_pkg
module slc_dp #(
   parameter int MAX_WAYS   = slc_pkg::MAX_WAYS_DEF,
   parameter int MAX_SETS   = slc_pkg::MAX_SETS_DEF,
   parameter int BLOCK_BITS = slc_pkg::BLOCK_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  slc_pkg::slc_cmd_type        cmd,
   output slc_pkg::slc_stat_type       stat,
   input  logic                        req_op,
   input  logic [BLOCK_BITS-1:0]       req_block,
   output logic                        rsp_action,
   output logic [BLOCK_BITS-1:0]       rsp_block,
   input  logic                        csr_wr,
   input  logic [slc_pkg::CSR_AW-1:0]  csr_addr,
   input  logic [slc_pkg::CSR_DW-1:0]  csr_wdata,
   output logic [slc_pkg::CSR_DW-1:0]  csr_rdata
);

   localparam int WR_W    = slc_pkg::WAYS_REG_W;
   localparam int SR_W    = slc_pkg::SETS_REG_W;
   localparam int RADIX   = slc_pkg::DIV_RADIX;
   localparam int STEPS   = (BLOCK_BITS + RADIX - 1) / RADIX;
   localparam int PAD_W   = STEPS * RADIX;
   localparam int CNT_W   = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int SET_IW  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WAY_IW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int AGE_W   = WAY_IW;
   localparam int LIM_W   = AGE_W + 1;
   localparam int FILL_W  = $clog2(MAX_WAYS + 1);
   localparam int AGE_TOT = MAX_WAYS * AGE_W;
   localparam int STAT_W  = AGE_TOT + MAX_WAYS + FILL_W;
   localparam int TAG_W   = MAX_WAYS * BLOCK_BITS;

   logic [WR_W-1:0]       ways_ff;
   logic [SR_W-1:0]       sets_ff;
   logic [WR_W-1:0]       weff_ff;
   logic [SR_W-1:0]       seff_ff;
   logic                  op_ff;
   logic [BLOCK_BITS-1:0] blk_ff;
   logic [PAD_W-1:0]      dvd_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [WR_W-1:0]       rw_ff, rw_in;
   logic [SR_W-1:0]       rs_ff, rs_in;
   logic [SET_IW-1:0]     set_idx;
   logic [MAX_SETS-1:0]   valid_ff;
   logic                  vrd_ff;
   logic [TAG_W-1:0]      tag_mem [MAX_SETS];
   logic [STAT_W-1:0]     stat_mem [MAX_SETS];
   logic [TAG_W-1:0]      tag_rd_ff, tag_row_in, tag_row_ff;
   logic [STAT_W-1:0]     stat_rd_ff, stat_row_in, stat_row_ff;
   logic                  hit_in, hit_ff, wb_in, wb_ff;
   logic [BLOCK_BITS-1:0] wb_blk_in, wb_blk_ff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ways_ff <= WR_W'(1);
         sets_ff <= SR_W'(1);
      end else if (csr_wr) begin
         unique case (csr_addr[2])
            slc_pkg::REG_WAYS: ways_ff <= csr_wdata[WR_W-1:0];
            slc_pkg::REG_SETS: sets_ff <= csr_wdata[SR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_addr[2])
         slc_pkg::REG_WAYS: csr_rdata = slc_pkg::CSR_DW'(ways_ff);
         slc_pkg::REG_SETS: csr_rdata = slc_pkg::CSR_DW'(sets_ff);
         default: csr_rdata = '0;
      endcase
   end

   // set mapping: quotient bits feed the set-count remainder msb first
   always_comb begin
      logic [WR_W-1:0] rw;
      logic [SR_W-1:0] rs;
      logic [WR_W:0]   rw2;
      logic [SR_W:0]   rs2;
      logic            qb;
      rw = rw_ff;
      rs = rs_ff;
      for (int b = 0; b < RADIX; b++) begin
         rw2 = {rw, dvd_ff[PAD_W-1-b]};
         qb  = (rw2 >= {1'b0, weff_ff});
         if (qb) rw2 = rw2 - {1'b0, weff_ff};
         rw  = rw2[WR_W-1:0];
         rs2 = {rs, qb};
         if (rs2 >= {1'b0, seff_ff}) rs2 = rs2 - {1'b0, seff_ff};
         rs  = rs2[SR_W-1:0];
      end
      rw_in = rw;
      rs_in = rs;
   end

   assign set_idx = SET_IW'(rs_ff);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_op;
         blk_ff <= req_block;
         dvd_ff <= PAD_W'(req_block);
         cnt_ff <= '0;
         rw_ff  <= '0;
         rs_ff  <= '0;
         if (ways_ff == '0) weff_ff <= WR_W'(1);
         else if (int'(ways_ff) > MAX_WAYS) weff_ff <= WR_W'(MAX_WAYS);
         else weff_ff <= ways_ff;
         if (sets_ff == '0) seff_ff <= SR_W'(1);
         else if (int'(sets_ff) > MAX_SETS) seff_ff <= SR_W'(MAX_SETS);
         else seff_ff <= sets_ff;
      end else if (cmd.step) begin
         dvd_ff <= dvd_ff << RADIX;
         cnt_ff <= cnt_ff + CNT_W'(1);
         rw_ff  <= rw_in;
         rs_ff  <= rs_in;
      end
   end

   assign stat.div_last = (cnt_ff == CNT_W'(STEPS - 1));
   assign stat.hit      = hit_ff;
   assign stat.need_wb  = wb_ff;

   // per-set valid bits stand in for the all-zero status reset
   always_ff @(posedge clock) begin
      if (reset || csr_wr) valid_ff <= '0;
      else if (cmd.mem_wr) valid_ff[set_idx] <= 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         tag_rd_ff  <= tag_mem[set_idx];
         stat_rd_ff <= stat_mem[set_idx];
         vrd_ff     <= valid_ff[set_idx];
      end
      if (cmd.mem_wr) begin
         tag_mem[set_idx]  <= tag_row_ff;
         stat_mem[set_idx] <= stat_row_ff;
      end
   end

   // tag compare, victim choice and age update
   always_comb begin
      logic [FILL_W-1:0] sfill, fill;
      logic [MAX_WAYS-1:0] dirty;
      logic [AGE_TOT-1:0]  ages;
      logic                hit, full;
      logic [WAY_IW-1:0]   hway, vway, slot;
      logic [AGE_W-1:0]    age_h;
      logic [LIM_W-1:0]    lim;
      sfill = vrd_ff ? stat_rd_ff[AGE_TOT+MAX_WAYS +: FILL_W] : '0;
      dirty = vrd_ff ? stat_rd_ff[AGE_TOT +: MAX_WAYS] : '0;
      ages  = vrd_ff ? stat_rd_ff[0 +: AGE_TOT] : '0;
      fill  = (int'(sfill) > int'(weff_ff)) ? FILL_W'(weff_ff) : sfill;
      full  = (int'(fill) == int'(weff_ff));
      hit   = 1'b0;
      hway  = '0;
      vway  = '0;
      age_h = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (w < int'(fill)) begin
            if (tag_rd_ff[w*BLOCK_BITS +: BLOCK_BITS] == blk_ff) begin
               hit   = 1'b1;
               hway  = WAY_IW'(w);
               age_h = ages[w*AGE_W +: AGE_W];
            end
            if (int'(ages[w*AGE_W +: AGE_W]) == int'(fill) - 1) vway = WAY_IW'(w);
         end
      end
      priority if (hit) begin
         slot = hway;
         lim  = {1'b0, age_h};
      end else if (full) begin
         slot = vway;
         lim  = LIM_W'(int'(fill) - 1);
      end else begin
         slot = WAY_IW'(fill);
         lim  = LIM_W'(1 << AGE_W);
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (w < int'(fill) && {1'b0, ages[w*AGE_W +: AGE_W]} < lim)
            ages[w*AGE_W +: AGE_W] = ages[w*AGE_W +: AGE_W] + AGE_W'(1);
      end
      wb_in     = !hit && full && dirty[vway];
      wb_blk_in = tag_rd_ff[vway*BLOCK_BITS +: BLOCK_BITS];
      hit_in    = hit;
      ages[slot*AGE_W +: AGE_W] = '0;
      if (hit) dirty[slot] = dirty[slot] | (op_ff == slc_pkg::OP_WRITE);
      else dirty[slot] = (op_ff == slc_pkg::OP_WRITE);
      if (!hit && !full) sfill = fill + FILL_W'(1);
      tag_row_in = tag_rd_ff;
      if (!hit) tag_row_in[slot*BLOCK_BITS +: BLOCK_BITS] = blk_ff;
      stat_row_in = {sfill, dirty, ages};
   end

   always_ff @(posedge clock) begin
      if (cmd.look) begin
         tag_row_ff  <= tag_row_in;
         stat_row_ff <= stat_row_in;
         hit_ff      <= hit_in;
         wb_ff       <= wb_in;
         wb_blk_ff   <= wb_blk_in;
      end
   end

   assign rsp_action = cmd.show_wb ? slc_pkg::ACT_WRITEBACK : slc_pkg::ACT_FETCH;
   assign rsp_block  = cmd.show_wb ? wb_blk_ff : blk_ff;

endmodule

// ===== rtl/slc_checker.sv =====
// port-level checks of the lru write-back cache, bound to the top level
// depends on slc_pkg and set_assoc_lru_writeback_cache
module slc_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic rsp_tuser,
   input logic rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid)
      else $error("response right after request transfer");

   a_wb_then_fetch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && rsp_tlast && rsp_tuser == slc_pkg::ACT_FETCH)
      else $error("write-back not followed by fetch");

   a_wb_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == slc_pkg::ACT_WRITEBACK |-> !rsp_tlast)
      else $error("write-back marked last");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while response pending");

endmodule

bind set_assoc_lru_writeback_cache slc_checker u_slc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
